// ----- rtl/core/plbe_pkg.sv -----
package plbe_pkg;

  localparam int unsigned       BUDGET_W        = 32;
  localparam int unsigned       TOTAL_W         = 36;
  localparam int unsigned       SIZE_W          = 31;
  localparam int unsigned       STAMP_W         = 32;
  localparam logic [31:0]       RESET_BUDGET    = 32'd62914560;
  localparam logic [SIZE_W-1:0] MAX_ENTRY_BYTES = 31'd1073741824;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_CLEANUP = 2'd2,
    ACT_FLUSH   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNPINNED  = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_SATURATED = 3'd3,
    ST_EVICTED   = 3'd4,
    ST_DONE      = 3'd5,
    ST_NONE      = 3'd6,
    ST_FLUSHED   = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_SCAN,
    S_PICK
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         slot;
    logic [SIZE_W-1:0]  entry_bytes;
    logic [STAMP_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               inserted;
    logic [4:0]         evicted_slot;
    logic [15:0]        pin_count;
    logic [TOTAL_W-1:0] total_bytes;
    logic [TOTAL_W-1:0] unused_bytes;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic emit_done;
    logic evict;
    logic emit_none;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic over_budget;
    logic scan_end;
    logic found;
  } stat_t;

endpackage

// ----- rtl/core/plbe_if.sv -----
interface plbe_in_if;
  import plbe_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plbe_out_if;
  import plbe_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plbe_cfg_if;
  import plbe_pkg::*;
  logic                valid;
  logic                ready;
  logic [BUDGET_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/plbe_ctrl.sv -----
module plbe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_action_i,
  output logic            in_ready_o,
  input  plbe_pkg::stat_t stat_i,
  output plbe_pkg::cmd_t  cmd_o
);
  import plbe_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (action_e'(in_action_i) == ACT_CLEANUP) ? S_CHECK : S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_CHECK: begin
        if (stat_i.over_budget) begin
          state_d = S_SCAN;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_end) state_d = S_PICK;
      end
      S_PICK: begin
        if (stat_i.out_free) state_d = stat_i.found ? S_CHECK : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.load = accept;
      S_EXEC:  cmd_o.exec = stat_i.out_free;
      S_CHECK: begin
        cmd_o.scan_start = stat_i.over_budget;
        cmd_o.emit_done  = !stat_i.over_budget && stat_i.out_free;
      end
      S_SCAN:  cmd_o.scan_step = 1'b1;
      S_PICK:  begin
        cmd_o.evict     = stat_i.out_free && stat_i.found;
        cmd_o.emit_none = stat_i.out_free && !stat_i.found;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/core/plbe_dp.sv -----
module plbe_dp #(
  parameter int unsigned ENTRIES   = 32,
  parameter int unsigned PIN_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [plbe_pkg::BUDGET_W-1:0] cfg_data_i,
  input  plbe_pkg::in_item_t            in_data_i,
  input  plbe_pkg::cmd_t                cmd_i,
  output plbe_pkg::stat_t               stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output plbe_pkg::out_item_t           out_data_o
);
  import plbe_pkg::*;

  localparam int unsigned          IW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0]        LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [PIN_WIDTH-1:0] PIN_MAX  = '1;
  localparam logic [PIN_WIDTH-1:0] PIN_ONE  = PIN_WIDTH'(1);

  logic [BUDGET_W-1:0]  budget_q;
  logic [ENTRIES-1:0]   valid_q;
  logic [TOTAL_W-1:0]   total_q, unused_q;

  action_e              action_q;
  logic [IW-1:0]        slot_q;
  logic                 in_range_q;
  logic [SIZE_W-1:0]    bytes_q;
  logic [STAMP_W-1:0]   now_q;

  logic [SIZE_W-1:0]    size_mem  [ENTRIES];
  logic [PIN_WIDTH-1:0] pins_mem  [ENTRIES];
  logic [STAMP_W-1:0]   stamp_mem [ENTRIES];
  logic [SIZE_W-1:0]    rd_size_q;
  logic [PIN_WIDTH-1:0] rd_pins_q;
  logic [STAMP_W-1:0]   rd_stamp_q;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;

  logic [IW-1:0]        idx_q, rd_idx_q, best_idx_q;
  logic                 issue_q, rd_vld_q, best_found_q;
  logic [STAMP_W-1:0]   best_stamp_q;
  logic [SIZE_W-1:0]    best_size_q;
  logic                 cand;

  logic                 out_valid_q;
  out_item_t            out_q;

  logic                 hit, wr_en, set_valid, flush;
  logic [SIZE_W-1:0]    wr_size, sat_bytes;
  logic [PIN_WIDTH-1:0] wr_pins, ex_pins;
  logic [STAMP_W-1:0]   wr_stamp;
  logic [TOTAL_W-1:0]   ex_total, ex_unused;
  status_e              ex_status;
  logic                 ex_ins;
  logic [31:0]          pins_ext;
  logic                 emit;
  out_item_t            out_d;

  assign rd_en   = cmd_i.load || (cmd_i.scan_step && issue_q);
  assign rd_addr = cmd_i.load ? IW'(in_data_i.slot) : idx_q;

  assign hit       = in_range_q && valid_q[slot_q];
  assign sat_bytes = (bytes_q > MAX_ENTRY_BYTES) ? MAX_ENTRY_BYTES : bytes_q;

  always_comb begin
    wr_en     = 1'b0;
    wr_size   = rd_size_q;
    wr_pins   = rd_pins_q;
    wr_stamp  = rd_stamp_q;
    set_valid = 1'b0;
    flush     = 1'b0;
    ex_total  = total_q;
    ex_unused = unused_q;
    ex_status = ST_OK;
    ex_ins    = 1'b0;
    ex_pins   = '0;
    unique case (action_q)
      ACT_ACQUIRE: begin
        if (!in_range_q) begin
          ex_status = ST_ABSENT;
        end else if (!valid_q[slot_q]) begin
          wr_en     = 1'b1;
          set_valid = 1'b1;
          wr_size   = sat_bytes;
          wr_pins   = PIN_ONE;
          wr_stamp  = '0;
          ex_total  = total_q + TOTAL_W'(sat_bytes);
          ex_ins    = 1'b1;
          ex_pins   = PIN_ONE;
        end else if (rd_pins_q == PIN_MAX) begin
          ex_status = ST_SATURATED;
          ex_pins   = rd_pins_q;
        end else begin
          wr_en   = 1'b1;
          wr_pins = rd_pins_q + PIN_ONE;
          ex_pins = wr_pins;
          if (rd_pins_q == '0) ex_unused = unused_q - TOTAL_W'(rd_size_q);
        end
      end
      ACT_RELEASE: begin
        if (!hit) begin
          ex_status = ST_ABSENT;
        end else if (rd_pins_q == '0) begin
          ex_status = ST_UNPINNED;
        end else begin
          wr_en   = 1'b1;
          wr_pins = rd_pins_q - PIN_ONE;
          ex_pins = wr_pins;
          if (rd_pins_q == PIN_ONE) begin
            wr_stamp  = now_q;
            ex_unused = unused_q + TOTAL_W'(rd_size_q);
          end
        end
      end
      ACT_FLUSH: begin
        flush     = 1'b1;
        ex_total  = '0;
        ex_unused = '0;
        ex_status = ST_FLUSHED;
      end
      ACT_CLEANUP: ex_status = ST_DONE;
      default:     ex_status = ST_OK;
    endcase
  end

  assign pins_ext = 32'(ex_pins);

  assign cand = rd_vld_q && valid_q[rd_idx_q] && (rd_pins_q == '0) &&
                (rd_stamp_q < best_stamp_q);

  assign emit = cmd_i.exec || cmd_i.emit_done || cmd_i.evict || cmd_i.emit_none;

  always_comb begin
    out_d              = '0;
    out_d.total_bytes  = total_q;
    out_d.unused_bytes = unused_q;
    out_d.last         = 1'b1;
    priority if (cmd_i.exec) begin
      out_d.status       = ex_status;
      out_d.inserted     = ex_ins;
      out_d.pin_count    = pins_ext[15:0];
      out_d.total_bytes  = ex_total;
      out_d.unused_bytes = ex_unused;
    end else if (cmd_i.evict) begin
      out_d.status       = ST_EVICTED;
      out_d.evicted_slot = 5'(best_idx_q);
      out_d.total_bytes  = total_q - TOTAL_W'(best_size_q);
      out_d.unused_bytes = unused_q - TOTAL_W'(best_size_q);
      out_d.last         = 1'b0;
    end else if (cmd_i.emit_none) begin
      out_d.status = ST_NONE;
    end else begin
      out_d.status = ST_DONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      size_mem[slot_q]  <= wr_size;
      pins_mem[slot_q]  <= wr_pins;
      stamp_mem[slot_q] <= wr_stamp;
    end
    if (rd_en) begin
      rd_size_q  <= size_mem[rd_addr];
      rd_pins_q  <= pins_mem[rd_addr];
      rd_stamp_q <= stamp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q   <= action_e'(in_data_i.action);
      slot_q     <= IW'(in_data_i.slot);
      in_range_q <= ({27'd0, in_data_i.slot} < 32'(ENTRIES));
      bytes_q    <= in_data_i.entry_bytes;
      now_q      <= in_data_i.now;
    end
    if (cmd_i.scan_step) rd_idx_q <= idx_q;
    if (cmd_i.scan_start) begin
      best_stamp_q <= now_q;
    end else if (cand) begin
      best_stamp_q <= rd_stamp_q;
      best_idx_q   <= rd_idx_q;
      best_size_q  <= rd_size_q;
    end
    if (emit) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q     <= RESET_BUDGET;
      valid_q      <= '0;
      total_q      <= '0;
      unused_q     <= '0;
      idx_q        <= '0;
      issue_q      <= 1'b0;
      rd_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) budget_q <= cfg_data_i;
      if (cmd_i.exec) begin
        total_q  <= ex_total;
        unused_q <= ex_unused;
        if (flush) begin
          valid_q <= '0;
        end else if (set_valid) begin
          valid_q[slot_q] <= 1'b1;
        end
      end
      if (cmd_i.evict) begin
        valid_q[best_idx_q] <= 1'b0;
        total_q             <= out_d.total_bytes;
        unused_q            <= out_d.unused_bytes;
      end
      if (cmd_i.scan_start) begin
        idx_q        <= '0;
        issue_q      <= 1'b1;
        rd_vld_q     <= 1'b0;
        best_found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rd_vld_q <= issue_q;
        if (issue_q) begin
          if (idx_q == LAST_IDX) begin
            issue_q <= 1'b0;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        if (cand) best_found_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.over_budget = (budget_q != '0) && (total_q > TOTAL_W'(budget_q));
  assign stat_o.scan_end    = rd_vld_q && (rd_idx_q == LAST_IDX);
  assign stat_o.found       = best_found_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/pinned_lru_budget_evictor_top.sv -----
// Acquire, release, flush: the result is registered in S_EXEC once the output register is free,
// and no new input is taken before that. Cleanup: budget check, then per eviction a scan of all
// entries (one table read per cycle through the single entry memory read port) and a pick;
// the final result ends the sequence. Output register: the next input transfer is taken while
// a result waits. Reset clears valid bits, totals, output valid and restores the byte budget;
// entry memory contents are left as they are.
module pinned_lru_budget_evictor_top #(
  parameter int unsigned ENTRIES   = 32,
  parameter int unsigned PIN_WIDTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  plbe_cfg_if.sink   cfg_i,
  plbe_in_if.sink    in_i,
  plbe_out_if.source out_o
);
  import plbe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  plbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.data.action),
    .in_ready_o  (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  plbe_dp #(
    .ENTRIES   (ENTRIES),
    .PIN_WIDTH (PIN_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec || cmd.emit_done || cmd.evict || cmd.emit_none) |-> stat.out_free)
    else $error("result written while output register busy");

  a_evict_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.evict |-> stat.found)
    else $error("eviction without candidate");

  a_scan_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_start |-> stat.over_budget)
    else $error("scan started within budget");

  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.total_bytes >= out_o.data.unused_bytes))
    else $error("unused bytes exceed total");

  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.evict |=> (out_o.valid && !out_o.data.last))
    else $error("eviction result marked last");
`endif

endmodule
